### rtl/gnss_lidar_timestamp_sync_macros.svh
// Assertion macros used by the checker file of the timestamp synchronizer.
// Depends on signals named clk and arst_n in the using scope.
`ifndef GNSS_LIDAR_TIMESTAMP_SYNC_MACROS_SVH
`define GNSS_LIDAR_TIMESTAMP_SYNC_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define GLTS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked implication, disabled while reset is asserted.
`define GLTS_IMPLY(lbl, pre, post, msg) \
	`GLTS_ASSERT(lbl, (pre) |=> (post), msg)

`endif

### rtl/glts_pkg.sv
// Package of the GNSS / lidar timestamp synchronizer.
// Holds the sequencer state type, register indexes and fixed field widths.
package glts_pkg;

	localparam int TIME_W = 48;
	localparam int TAG_W = 16;
	localparam int STD_W = 16;
	localparam int ACC_W = 34;
	localparam int WIN_W = 32;
	localparam int IDX_OUT_W = 10;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 34;

	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THROTTLE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_STD = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LD,
		ST_LDC,
		ST_SQ,
		ST_THR,
		ST_SL,
		ST_SC,
		ST_EM,
		ST_UPD
	} state_t;

endpackage

### rtl/glts_frame_ram.sv
// Frame time memory of the timestamp synchronizer.
// One write port and one registered read port; uses glts_pkg for the data width.
module glts_frame_ram
	import glts_pkg::*;
#(
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [TIME_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [TIME_W-1:0]        rdata
);

	logic [TIME_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/gnss_lidar_timestamp_sync.sv
// Top level of the GNSS / lidar timestamp synchronizer.
// Uses glts_pkg and glts_frame_ram.
//
// Input channel (in_valid / in_stall): kind 0 beats load one frame time into the
// sorted list of lidar_slot; kind 1 beats present a GNSS fix. Output channel
// (out_valid / out_stall): one beat per active slot for each emitted fix pair,
// last marks the final beat. Configuration (cfg_valid / cfg_ready) is always ready.
// A fix passes checks in order (the accepting cycle, three squares through one shared
// multiplier, then the std limit and throttle compare), then a search of each active slot,
// which reads the frame memory one entry a cycle; a full match ends by updating the held
// fix, after the rows of an emitted pair. The input is stalled while an item is in work.
// After reset all lists are empty, no fix is held and the registers hold their defaults.
// When the receiver stalls, the current row holds in the output register and the
// sequencer waits before loading the next row.
module gnss_lidar_timestamp_sync
	import glts_pkg::*;
#(
	parameter int MAX_LIDARS = 4,
	parameter int FRAMES_PER_LIDAR = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  kind,
	input  logic [1:0]            lidar_slot,
	input  logic [TIME_W-1:0]     time_us,
	input  logic [TAG_W-1:0]      fix_tag,
	input  logic [STD_W-1:0]      std_x_mm,
	input  logic [STD_W-1:0]      std_y_mm,
	input  logic [STD_W-1:0]      std_z_mm,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [TAG_W-1:0]      curr_tag,
	output logic [TIME_W-1:0]     curr_time_us,
	output logic [TAG_W-1:0]      next_tag,
	output logic [TIME_W-1:0]     next_time_us,
	output logic [1:0]            out_slot,
	output logic [IDX_OUT_W-1:0]  frame_index,
	output logic                  last,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SW = (MAX_LIDARS > 1) ? $clog2(MAX_LIDARS) : 1;
	localparam int NW = SW + 1;
	localparam int CNTW = $clog2(FRAMES_PER_LIDAR + 1);
	localparam int IW = $clog2(FRAMES_PER_LIDAR);
	localparam int DEPTH = MAX_LIDARS * FRAMES_PER_LIDAR;
	localparam int AW = $clog2(DEPTH);

	state_t state_q, state_d;

	logic [2:0]        active_q;
	logic [WIN_W-1:0]  window_q;
	logic [WIN_W-1:0]  throttle_q;
	logic [ACC_W-1:0]  max_std_q;

	logic [1:0]        slot_q;
	logic [TIME_W-1:0] t_q;
	logic [TAG_W-1:0]  tag_q;
	logic [STD_W-1:0]  sx_q, sy_q, sz_q;
	logic [ACC_W-1:0]  acc_q;
	logic [1:0]        sq_cnt_q;
	logic [SW-1:0]     s_q;
	logic [CNTW-1:0]   i_q;

	logic [CNTW-1:0]   count_q [MAX_LIDARS];
	logic [IW-1:0]     cursor_q [MAX_LIDARS];
	logic [IW-1:0]     found_q [MAX_LIDARS];
	logic [IW-1:0]     held_match_q [MAX_LIDARS];
	logic [TIME_W-1:0] last_proc_q;
	logic              held_valid_q;
	logic [TIME_W-1:0] held_time_q;
	logic [TAG_W-1:0]  held_tag_q;

	logic              out_valid_q;

	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [TIME_W-1:0] ram_rdata;

	logic [NW-1:0]     na;
	logic [SW-1:0]     lsidx;
	logic              slot_ok;
	logic [CNTW-1:0]   ld_n;
	logic [CNTW-1:0]   sn;
	logic [CNTW-1:0]   cur_ext;
	logic [CNTW-1:0]   i_next;
	logic              last_slot;
	logic [STD_W-1:0]  sq_op;
	logic [2*STD_W-1:0] sq_prod;
	logic              row_load;

	glts_frame_ram #(
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(t_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		if (active_q == 3'd0) begin
			na = NW'(1);
		end else if (32'(active_q) > MAX_LIDARS) begin
			na = NW'(MAX_LIDARS);
		end else begin
			na = NW'(active_q);
		end
	end

	assign lsidx = SW'(slot_q);
	assign slot_ok = (32'(slot_q) < MAX_LIDARS);
	assign ld_n = count_q[lsidx];
	assign sn = count_q[s_q];
	assign cur_ext = CNTW'(cursor_q[s_q]);
	assign i_next = i_q + CNTW'(1);
	assign last_slot = ((NW'(s_q) + NW'(1)) == na);
	assign row_load = (state_q == ST_EM) && (!out_valid_q || !out_stall);

	always_comb begin
		case (sq_cnt_q)
			2'd0: sq_op = sx_q;
			2'd1: sq_op = sy_q;
			default: sq_op = sz_q;
		endcase
	end
	assign sq_prod = sq_op * sq_op;

	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_re = 1'b0;
		ram_waddr = AW'(AW'(lsidx) * AW'(FRAMES_PER_LIDAR) + AW'(ld_n));
		ram_raddr = AW'(AW'(lsidx) * AW'(FRAMES_PER_LIDAR) + AW'(ld_n - CNTW'(1)));
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = kind ? ST_SQ : ST_LD;
				end
			end
			ST_LD: begin
				if (!slot_ok || 32'(ld_n) >= FRAMES_PER_LIDAR) begin
					state_d = ST_IDLE;
				end else if (ld_n == '0) begin
					ram_we = 1'b1;
					state_d = ST_IDLE;
				end else begin
					ram_re = 1'b1;
					state_d = ST_LDC;
				end
			end
			ST_LDC: begin
				ram_we = (t_q >= ram_rdata);
				state_d = ST_IDLE;
			end
			ST_SQ: begin
				if (sq_cnt_q == 2'd2) begin
					state_d = ST_THR;
				end
			end
			ST_THR: begin
				if (acc_q > max_std_q) begin
					state_d = ST_IDLE;
				end else if (last_proc_q != '0 && (t_q < last_proc_q ||
						(t_q - last_proc_q) < TIME_W'(throttle_q))) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_SL;
				end
			end
			ST_SL: begin
				ram_raddr = AW'(AW'(s_q) * AW'(FRAMES_PER_LIDAR) + AW'(cur_ext));
				if (sn == '0 || cur_ext >= sn) begin
					state_d = ST_IDLE;
				end else begin
					ram_re = 1'b1;
					state_d = ST_SC;
				end
			end
			ST_SC: begin
				ram_raddr = AW'(AW'(s_q) * AW'(FRAMES_PER_LIDAR) + AW'(i_next));
				if (ram_rdata < t_q) begin
					if (i_next >= sn) begin
						state_d = ST_IDLE;
					end else begin
						ram_re = 1'b1;
					end
				end else if ((ram_rdata - t_q) > TIME_W'(window_q)) begin
					state_d = ST_IDLE;
				end else if (last_slot) begin
					state_d = held_valid_q ? ST_EM : ST_UPD;
				end else begin
					state_d = ST_SL;
				end
			end
			ST_EM: begin
				if (row_load && last_slot) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 3'd1;
			window_q <= WIN_W'(100000);
			throttle_q <= WIN_W'(60000);
			max_std_q <= ACC_W'(2500);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ACTIVE: active_q <= cfg_data[2:0];
				REG_WINDOW: window_q <= cfg_data[WIN_W-1:0];
				REG_THROTTLE: throttle_q <= cfg_data[WIN_W-1:0];
				REG_MAX_STD: max_std_q <= cfg_data[ACC_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			slot_q <= lidar_slot;
			t_q <= time_us;
			tag_q <= fix_tag;
			sx_q <= std_x_mm;
			sy_q <= std_y_mm;
			sz_q <= std_z_mm;
			acc_q <= '0;
			sq_cnt_q <= 2'd0;
		end
		if (state_q == ST_SQ) begin
			acc_q <= acc_q + ACC_W'(sq_prod);
			sq_cnt_q <= sq_cnt_q + 2'd1;
		end
		if (state_q == ST_SL) begin
			i_q <= cur_ext;
		end
		if (state_q == ST_SC && ram_rdata < t_q) begin
			i_q <= i_next;
		end
		if (state_q == ST_SC && ram_rdata >= t_q) begin
			found_q[s_q] <= IW'(i_q);
		end
		if (row_load) begin
			curr_tag <= held_tag_q;
			curr_time_us <= held_time_q;
			next_tag <= tag_q;
			next_time_us <= t_q;
			out_slot <= 2'(s_q);
			frame_index <= IDX_OUT_W'(held_match_q[s_q]);
			last <= last_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q <= '0;
			for (int k = 0; k < MAX_LIDARS; k++) begin
				count_q[k] <= '0;
				cursor_q[k] <= '0;
				held_match_q[k] <= '0;
			end
			last_proc_q <= '0;
			held_valid_q <= 1'b0;
			held_time_q <= '0;
			held_tag_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ram_we) begin
				count_q[lsidx] <= ld_n + CNTW'(1);
			end
			if (state_q == ST_THR && state_d == ST_SL) begin
				last_proc_q <= t_q;
				s_q <= '0;
			end
			if (state_q == ST_SC && ram_rdata >= t_q && state_d != ST_IDLE) begin
				cursor_q[s_q] <= IW'(i_q);
				s_q <= last_slot ? '0 : s_q + SW'(1);
			end
			if (row_load) begin
				s_q <= s_q + SW'(1);
			end
			if (state_q == ST_UPD) begin
				held_valid_q <= 1'b1;
				held_time_q <= t_q;
				held_tag_q <= tag_q;
				for (int k = 0; k < MAX_LIDARS; k++) begin
					if (NW'(k) < na) begin
						held_match_q[k] <= found_q[k];
					end
				end
			end
			if (row_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/glts_checker.sv
// Port-level checker of the timestamp synchronizer and its bind statement.
// Depends on gnss_lidar_timestamp_sync_macros.svh.
`include "gnss_lidar_timestamp_sync_macros.svh"

module glts_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] out_slot,
	input logic       last
);

	`GLTS_IMPLY(a_out_hold, out_valid && out_stall, out_valid, "Stalled beat was dropped.")
	`GLTS_IMPLY(a_busy_after_accept, in_valid && !in_stall, in_stall, "Input not stalled after a beat.")
	`GLTS_IMPLY(a_rows_contiguous, out_valid && !out_stall && !last, out_valid, "Gap inside a pair.")
	`GLTS_IMPLY(a_slot_steps, out_valid && !out_stall && !last, out_slot == $past(out_slot) + 2'd1, "Slot order broken.")

endmodule

bind gnss_lidar_timestamp_sync glts_checker u_glts_checker (.*);
